FILE: hdl/cbfp_pkg.sv
// Package: shared constants, register indexes and command types for the footprint publisher.
`default_nettype none
package cbfp_pkg;
  localparam int unsigned AddrW = 5;
  localparam logic [2:0] RegThr   = 3'd0;
  localparam logic [2:0] RegSigma = 3'd1;
  localparam logic [2:0] RegMargin = 3'd2;
  localparam logic [2:0] RegSensX = 3'd3;
  localparam logic [2:0] RegSensY = 3'd4;

  localparam logic signed [17:0] YawTrigger = 18'sd410;
  localparam logic [14:0] ExtentFloor = 15'd51;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [17:0] CordicStart = 18'sd9949;
  localparam int unsigned CordicSteps = 16;

  function automatic logic [15:0] atan_lut(input logic [3:0] i);
    logic [15:0] r;
    begin
      case (i)
        4'd0: r = 16'd51472;
        4'd1: r = 16'd30386;
        4'd2: r = 16'd16055;
        4'd3: r = 16'd8150;
        4'd4: r = 16'd4091;
        4'd5: r = 16'd2047;
        4'd6: r = 16'd1024;
        4'd7: r = 16'd512;
        4'd8: r = 16'd256;
        4'd9: r = 16'd128;
        4'd10: r = 16'd64;
        4'd11: r = 16'd32;
        4'd12: r = 16'd16;
        4'd13: r = 16'd8;
        4'd14: r = 16'd4;
        default: r = 16'd2;
      endcase
      return r;
    end
  endfunction

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture request, check change
    logic sqrt_init;
    logic sqrt_step;
    logic infl;      // sigma multiply
    logic ext;       // extents + range
    logic cordic_init;
    logic cordic_step;
    logic proj;      // p1/p2 products
    logic tsum;      // |p1|*width, |p2|*depth products
    logic num;       // T from the rounded product sum
    logic div_init;
    logic div_step;
    logic fin;       // result + state update
  } cbfp_cmd_t;

  typedef struct packed {
    logic changed;
    logic anchor;    // q > 1 and near valid
  } cbfp_sts_t;
endpackage
`default_nettype wire

FILE: hdl/cbfp_ctrl.sv
// Controller: sequences one request through the shared iterative datapath steps.
`default_nettype none
module cbfp_ctrl
  import cbfp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire cbfp_sts_t sts_i,
  output cbfp_cmd_t      cmd_o
);
  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StCheck  = 12'b000000000010,
    StSqrt   = 12'b000000000100,
    StInfl   = 12'b000000001000,
    StExt    = 12'b000000010000,
    StCordic = 12'b000000100000,
    StProj   = 12'b000001000000,
    StTsum   = 12'b000010000000,
    StNum    = 12'b000100000000,
    StDiv    = 12'b001000000000,
    StFin    = 12'b010000000000,
    StOut    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q + 6'd1;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        cnt_d = '0;
        if (sts_i.changed) begin
          cmd_o.sqrt_init = 1'b1;
          state_d = StSqrt;
        end else begin
          state_d = StIdle;
        end
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == 6'd10) state_d = StInfl;
      end
      StInfl: begin
        cmd_o.infl = 1'b1;
        state_d = StExt;
      end
      StExt: begin
        cmd_o.ext = 1'b1;
        cmd_o.cordic_init = 1'b1;
        cnt_d = '0;
        state_d = StCordic;
      end
      StCordic: begin
        if (!sts_i.anchor) begin
          state_d = StFin;
        end else begin
          cmd_o.cordic_step = 1'b1;
          if (cnt_q == 6'(CordicSteps - 1)) state_d = StProj;
        end
      end
      StProj: begin
        cmd_o.proj = 1'b1;
        state_d = StTsum;
      end
      StTsum: begin
        cmd_o.tsum = 1'b1;
        state_d = StNum;
      end
      StNum: begin
        cmd_o.num = 1'b1;
        cnt_d = '0;
        state_d = StDiv;
      end
      StDiv: begin
        if (cnt_q == 6'd0) begin
          cmd_o.div_init = 1'b1;
        end else begin
          cmd_o.div_step = 1'b1;
        end
        if (cnt_q == 6'd48) state_d = StFin;
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/cbfp_dp.sv
// Datapath: change test, square roots, CORDIC, projection and restoring divider.
`default_nettype none
module cbfp_dp
  import cbfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cbfp_cmd_t          cmd_i,
  output cbfp_sts_t               sts_o,
  input  wire logic [14:0]        thr_i,
  input  wire logic [11:0]        sigma_i,
  input  wire logic [11:0]        margin_i,
  input  wire logic signed [15:0] sens_x_i,
  input  wire logic signed [15:0] sens_y_i,
  input  wire logic signed [15:0] fit_center_x_i,
  input  wire logic signed [15:0] fit_center_y_i,
  input  wire logic [14:0]        fit_width_i,
  input  wire logic [14:0]        fit_depth_i,
  input  wire logic [14:0]        fit_height_i,
  input  wire logic signed [15:0] fit_yaw_i,
  input  wire logic [19:0]        width_variance_i,
  input  wire logic [19:0]        depth_variance_i,
  input  wire logic               belief_valid_i,
  input  wire logic signed [15:0] near_x_i,
  input  wire logic signed [15:0] near_y_i,
  input  wire logic               near_valid_i,
  output logic signed [15:0]      pub_center_x_o,
  output logic signed [15:0]      pub_center_y_o,
  output logic [14:0]             pub_width_o,
  output logic [14:0]             pub_depth_o,
  output logic [14:0]             pub_height_o,
  output logic [31:0]             generation_o
);
  // captured request
  logic signed [15:0] cx_q, cy_q, yaw_q, nx_q, ny_q;
  logic [14:0] w_q, d_q, h_q;
  logic [19:0] wv_q, dv_q;
  logic bel_q, nok_q;
  // state
  logic signed [15:0] lcx_q, lcy_q, lyaw_q;
  logic [14:0] lw_q, ld_q;
  logic [31:0] gen_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= fit_center_x_i; cy_q <= fit_center_y_i; yaw_q <= fit_yaw_i;
      nx_q <= near_x_i; ny_q <= near_y_i;
      w_q <= fit_width_i; d_q <= fit_depth_i; h_q <= fit_height_i;
      wv_q <= width_variance_i; dv_q <= depth_variance_i;
      bel_q <= belief_valid_i; nok_q <= near_valid_i;
    end
  end

  // change test
  logic signed [16:0] dcx, dcy, dw, dd, dyw;
  logic [16:0] thr17;
  always_comb begin
    dcx = 17'(cx_q) - 17'(lcx_q);
    dcy = 17'(cy_q) - 17'(lcy_q);
    dw = $signed({2'b0, w_q}) - $signed({2'b0, lw_q});
    dd = $signed({2'b0, d_q}) - $signed({2'b0, ld_q});
    dyw = 17'(yaw_q) - 17'(lyaw_q);
    thr17 = {2'b0, thr_i};
  end
  function automatic logic [16:0] mag(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : v;
  endfunction

  // two bit-pair square roots in parallel, one pair per cycle
  logic [21:0] rw_q, rd_q, vw_q, vd_q, bit_q;
  logic [21:0] tw, td;
  always_comb begin
    tw = rw_q + bit_q;
    td = rd_q + bit_q;
  end

  // extents and range
  logic [22:0] iw_q, id_q;
  logic [14:0] wp_q, dp_q, hp_q;
  logic signed [16:0] dx_q, dy_q;
  logic [33:0] qq_q;
  logic anchor_q;
  function automatic logic [14:0] clampx(input logic [23:0] v);
    if (v < 24'(ExtentFloor)) return ExtentFloor;
    if (v > 24'd32767) return 15'd32767;
    return v[14:0];
  endfunction
  logic [12:0] grow;
  logic signed [16:0] dxn, dyn;
  logic [15:0] adxn, adyn;
  logic [31:0] sqx, sqy;
  logic [33:0] qn;
  assign grow = {margin_i, 1'b0};
  assign dxn = 17'(cx_q) - 17'(sens_x_i);
  assign dyn = 17'(cy_q) - 17'(sens_y_i);
  assign adxn = 16'(mag(dxn));
  assign adyn = 16'(mag(dyn));
  assign sqx = adxn * adxn;
  assign sqy = adyn * adyn;
  assign qn = 34'(sqx) + 34'(sqy);

  always_comb begin
    sts_o.changed = (mag(dcx) > thr17) || (mag(dcy) > thr17) || (mag(dw) > thr17) ||
                    (mag(dd) > thr17) || (mag(dyw) > 17'(YawTrigger));
    sts_o.anchor = anchor_q;
  end

  // CORDIC
  logic signed [20:0] zc_q;
  logic signed [17:0] xc_q, yc_q;
  logic [3:0] ci_q;
  logic negc_q;
  logic signed [20:0] z0;
  logic z0neg;
  always_comb begin
    z0 = 21'(yaw_q) <<< 3;
    z0neg = 1'b0;
    if (z0 > 21'(HalfPiQ16)) begin
      z0 = z0 - 21'(PiQ16); z0neg = 1'b1;
    end else if (z0 < -21'(HalfPiQ16)) begin
      z0 = z0 + 21'(PiQ16); z0neg = 1'b1;
    end
  end
  logic signed [17:0] xs, ys;
  assign xs = xc_q >>> ci_q;
  assign ys = yc_q >>> ci_q;
  logic signed [17:0] cs, sn;
  assign cs = negc_q ? -xc_q : xc_q;
  assign sn = negc_q ? -yc_q : yc_q;

  // projection: four products registered, then sums
  logic signed [35:0] pa_q, pb_q, pc_q, pd_q;
  logic [36:0] ap1, ap2;
  logic signed [36:0] p1, p2;
  assign p1 = 37'(pa_q) + 37'(pb_q);
  assign p2 = 37'(pc_q) - 37'(pd_q);
  assign ap1 = p1[36] ? 37'(-p1) : 37'(p1);
  assign ap2 = p2[36] ? 37'(-p2) : 37'(p2);
  logic [51:0] m1_q, m2_q;
  logic [31:0] t_q;
  logic [52:0] tsum;
  assign tsum = 53'(m1_q) + 53'(m2_q) + 53'd16384;

  // divider: |T*dx| and |T*dy| by q, both in parallel, 48 dividend bits
  logic sxn_q, syn_q;
  logic [33:0] halfq;
  assign halfq = qq_q >> 1;
  logic [15:0] tdx_a, tdy_a;
  logic [47:0] pnx, pny;
  assign tdx_a = 16'(mag(dx_q));
  assign tdy_a = 16'(mag(dy_q));
  assign pnx = t_q * tdx_a;
  assign pny = t_q * tdy_a;
  logic [47:0] axq_q, ayq_q;
  logic [34:0] rx_q, ry_q;
  logic [34:0] rxs, rys;
  assign rxs = {rx_q[33:0], axq_q[47]};
  assign rys = {ry_q[33:0], ayq_q[47]};

  // final sums
  logic signed [57:0] ox, oy, fx, fy;
  function automatic logic signed [15:0] sat(input logic signed [57:0] v);
    if (v > 58'sd32767) return 16'sh7fff;
    if (v < -58'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
  assign ox = sxn_q ? -$signed({10'b0, axq_q}) : $signed({10'b0, axq_q});
  assign oy = syn_q ? -$signed({10'b0, ayq_q}) : $signed({10'b0, ayq_q});
  assign fx = 58'(nx_q) + ox;
  assign fy = 58'(ny_q) + oy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rw_q <= '0; rd_q <= '0;
      vw_q <= 22'(wv_q); vd_q <= 22'(dv_q);
      bit_q <= 22'h100000;
    end else if (cmd_i.sqrt_step) begin
      if (vw_q >= tw) begin
        vw_q <= vw_q - tw; rw_q <= (rw_q >> 1) + bit_q;
      end else rw_q <= rw_q >> 1;
      if (vd_q >= td) begin
        vd_q <= vd_q - td; rd_q <= (rd_q >> 1) + bit_q;
      end else rd_q <= rd_q >> 1;
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.infl) begin
      iw_q <= bel_q ? 23'((24'(sigma_i) * 24'(rw_q[9:0]) + 24'd128) >> 8) : '0;
      id_q <= bel_q ? 23'((24'(sigma_i) * 24'(rd_q[9:0]) + 24'd128) >> 8) : '0;
    end
    if (cmd_i.ext) begin
      wp_q <= clampx(24'(w_q) + 24'(iw_q) + 24'(grow));
      dp_q <= clampx(24'(d_q) + 24'(id_q) + 24'(grow));
      hp_q <= clampx(24'(h_q) + 24'(grow));
      dx_q <= dxn; dy_q <= dyn;
      qq_q <= qn;
    end
    if (cmd_i.cordic_init) begin
      zc_q <= z0; negc_q <= z0neg;
      xc_q <= CordicStart; yc_q <= '0; ci_q <= '0;
    end else if (cmd_i.cordic_step) begin
      if (!zc_q[20]) begin
        xc_q <= xc_q - ys; yc_q <= yc_q + xs;
        zc_q <= zc_q - 21'(atan_lut(ci_q));
      end else begin
        xc_q <= xc_q + ys; yc_q <= yc_q - xs;
        zc_q <= zc_q + 21'(atan_lut(ci_q));
      end
      ci_q <= ci_q + 4'd1;
    end
    if (cmd_i.proj) begin
      pa_q <= 36'(dx_q) * 36'(cs);
      pb_q <= 36'(dy_q) * 36'(sn);
      pc_q <= 36'(dy_q) * 36'(cs);
      pd_q <= 36'(dx_q) * 36'(sn);
    end
    if (cmd_i.tsum) begin
      m1_q <= 52'(ap1) * 52'(wp_q);
      m2_q <= 52'(ap2) * 52'(dp_q);
    end
    if (cmd_i.num) t_q <= tsum[46:15];
    if (cmd_i.div_init) begin
      axq_q <= pnx + 48'(halfq);
      ayq_q <= pny + 48'(halfq);
      sxn_q <= dx_q[16]; syn_q <= dy_q[16];
      rx_q <= '0; ry_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rxs >= 35'(qq_q)) begin
        rx_q <= rxs - 35'(qq_q); axq_q <= {axq_q[46:0], 1'b1};
      end else begin
        rx_q <= rxs; axq_q <= {axq_q[46:0], 1'b0};
      end
      if (rys >= 35'(qq_q)) begin
        ry_q <= rys - 35'(qq_q); ayq_q <= {ayq_q[46:0], 1'b1};
      end else begin
        ry_q <= rys; ayq_q <= {ayq_q[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcx_q <= '0; lcy_q <= '0; lyaw_q <= '0; lw_q <= '0; ld_q <= '0;
      gen_q <= '0; anchor_q <= 1'b0;
    end else begin
      if (cmd_i.ext) anchor_q <= (qn > 34'd1) && nok_q;
      if (cmd_i.sqrt_init) begin
        lcx_q <= cx_q; lcy_q <= cy_q; lyaw_q <= yaw_q; lw_q <= w_q; ld_q <= d_q;
      end
      if (cmd_i.fin) gen_q <= gen_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      pub_center_x_o <= anchor_q ? sat(fx) : cx_q;
      pub_center_y_o <= anchor_q ? sat(fy) : cy_q;
      pub_width_o <= wp_q;
      pub_depth_o <= dp_q;
      pub_height_o <= hp_q;
    end
  end
  assign generation_o = gen_q;
endmodule
`default_nettype wire

FILE: hdl/cbfp_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module cbfp_regs
  import cbfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [14:0]           thr_o,
  output logic [11:0]           sigma_o,
  output logic [11:0]           margin_o,
  output logic signed [15:0]    sens_x_o,
  output logic signed [15:0]    sens_y_o
);
  logic [2:0] idx;
  logic hi;
  assign idx = paddr[4:2];
  assign hi = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_o <= 15'd51; sigma_o <= 12'd256; margin_o <= 12'd102;
      sens_x_o <= '0; sens_y_o <= '0;
    end else if (psel && penable && pwrite && !hi) begin
      case (idx)
        RegThr: thr_o <= pwdata[14:0];
        RegSigma: sigma_o <= pwdata[11:0];
        RegMargin: margin_o <= pwdata[11:0];
        RegSensX: sens_x_o <= pwdata[15:0];
        RegSensY: sens_y_o <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegThr: prdata = {17'd0, thr_o};
      RegSigma: prdata = {20'd0, sigma_o};
      RegMargin: prdata = {20'd0, margin_o};
      RegSensX: prdata = {{16{sens_x_o[15]}}, sens_x_o};
      RegSensY: prdata = {{16{sens_y_o[15]}}, sens_y_o};
      default: prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/conservative_box_footprint_publisher_top.sv
// Top level: footprint publisher with config registers, controller and datapath.
// Flow: a request that does not publish ends after the change check; a published box goes
// through root, inflate and extent steps, and when anchored also CORDIC, projection and divide.
// One request in flight; the next is taken the cycle after the result is accepted, so a new
// request is not taken until the last one is done and its result, if any, is accepted.
// Reset (async, active low) clears the controller, the stored last box and the generation.
`default_nettype none
module conservative_box_footprint_publisher_top
  import cbfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [15:0]      fit_center_x_i,
  input  wire logic [15:0]      fit_center_y_i,
  input  wire logic [14:0]      fit_width_i,
  input  wire logic [14:0]      fit_depth_i,
  input  wire logic [14:0]      fit_height_i,
  input  wire logic [15:0]      fit_yaw_i,
  input  wire logic [19:0]      width_variance_i,
  input  wire logic [19:0]      depth_variance_i,
  input  wire logic             belief_valid_i,
  input  wire logic [15:0]      near_x_i,
  input  wire logic [15:0]      near_y_i,
  input  wire logic             near_valid_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [15:0]           pub_center_x_o,
  output logic [15:0]           pub_center_y_o,
  output logic [14:0]           pub_width_o,
  output logic [14:0]           pub_depth_o,
  output logic [14:0]           pub_height_o,
  output logic [31:0]           generation_o
);
  logic [14:0] thr;
  logic [11:0] sigma, margin;
  logic signed [15:0] sx, sy;
  cbfp_cmd_t cmd;
  cbfp_sts_t sts;

  cbfp_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .thr_o(thr), .sigma_o(sigma), .margin_o(margin), .sens_x_o(sx), .sens_y_o(sy)
  );

  cbfp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  cbfp_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .thr_i(thr), .sigma_i(sigma), .margin_i(margin), .sens_x_i(sx), .sens_y_i(sy),
    .fit_center_x_i, .fit_center_y_i, .fit_width_i, .fit_depth_i, .fit_height_i,
    .fit_yaw_i, .width_variance_i, .depth_variance_i, .belief_valid_i,
    .near_x_i, .near_y_i, .near_valid_i,
    .pub_center_x_o, .pub_center_y_o, .pub_width_o, .pub_depth_o, .pub_height_o,
    .generation_o
  );
endmodule
`default_nettype wire

FILE: test/tb_conservative_box_footprint_publisher_top.sv
// Testbench: random and directed box fits checked against a behavioral footprint predictor.
`default_nettype none
module tb_conservative_box_footprint_publisher_top;
  import cbfp_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [14:0] w;
    logic [14:0] d;
    logic [14:0] h;
    logic [15:0] yaw;
    logic [19:0] wv;
    logic [19:0] dv;
    logic        belief;
    logic [15:0] nx;
    logic [15:0] ny;
    logic        near_ok;
  } fit_t;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [14:0] w;
    logic [14:0] d;
    logic [14:0] h;
    logic [31:0] gen;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  fit_t fit_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  wire box_t box_o;

  conservative_box_footprint_publisher_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .fit_center_x_i(fit_q.cx), .fit_center_y_i(fit_q.cy),
    .fit_width_i(fit_q.w), .fit_depth_i(fit_q.d), .fit_height_i(fit_q.h),
    .fit_yaw_i(fit_q.yaw), .width_variance_i(fit_q.wv), .depth_variance_i(fit_q.dv),
    .belief_valid_i(fit_q.belief), .near_x_i(fit_q.nx), .near_y_i(fit_q.ny),
    .near_valid_i(fit_q.near_ok),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .pub_center_x_o(box_o.cx), .pub_center_y_o(box_o.cy),
    .pub_width_o(box_o.w), .pub_depth_o(box_o.d), .pub_height_o(box_o.h),
    .generation_o(box_o.gen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  longint thr_r, sigma_r, margin_r, sens_x_r, sens_y_r;
  longint last_cx, last_cy, last_w, last_d, last_yaw;
  logic [31:0] pub_count;

  fit_t fit_pending[$];
  box_t box_expected[$];
  int errors = 0;
  bit drive_idle_ok = 1'b1;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int stall_left = 0, gap_left = 0;
  int quiet_cycles = 0;

  function automatic void add_fit(fit_t f);
    fit_pending = {fit_pending, f};
  endfunction

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint div_half_away(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint sat_s16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint clamp_ext(longint v);
    if (v < 51) return 51;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic void rotate_unit(longint yaw_q13, output longint c, output longint s);
    longint z, x, y, xn;
    bit flip;
    longint ang[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2};
    z = yaw_q13 * 8;
    x = 9949;
    y = 0;
    flip = 1'b0;
    if (z > 102944) begin
      z -= 205887; flip = 1'b1;
    end else if (z < -102944) begin
      z += 205887; flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        xn = x - shr_floor(y, i); y = y + shr_floor(x, i); z -= ang[i];
      end else begin
        xn = x + shr_floor(y, i); y = y - shr_floor(x, i); z += ang[i];
      end
      x = xn;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // returns 1 and fills the box when the fit is published
  function automatic bit publish_footprint(fit_t f, output box_t b);
    longint cx, cy, w, d, h, yaw, iw, id, grow, wp, dp, hp, dx, dy, q;
    longint c, s, p1, p2, t, pcx, pcy;
    cx = longint'($signed(f.cx));
    cy = longint'($signed(f.cy));
    w = f.w; d = f.d; h = f.h;
    yaw = longint'($signed(f.yaw));
    if (!(mag(cx - last_cx) > thr_r || mag(cy - last_cy) > thr_r ||
          mag(w - last_w) > thr_r || mag(d - last_d) > thr_r ||
          mag(yaw - last_yaw) > 410))
      return 1'b0;
    last_cx = cx; last_cy = cy; last_w = w; last_d = d; last_yaw = yaw;
    iw = 0; id = 0;
    if (f.belief) begin
      iw = (sigma_r * root_floor(f.wv) + 128) >>> 8;
      id = (sigma_r * root_floor(f.dv) + 128) >>> 8;
    end
    grow = 2 * margin_r;
    wp = clamp_ext(w + iw + grow);
    dp = clamp_ext(d + id + grow);
    hp = clamp_ext(h + grow);
    pcx = cx; pcy = cy;
    dx = cx - sens_x_r;
    dy = cy - sens_y_r;
    q = dx * dx + dy * dy;
    if (q > 1 && f.near_ok) begin
      rotate_unit(yaw, c, s);
      p1 = dx * c + dy * s;
      p2 = dy * c - dx * s;
      t = (wp * mag(p1) + dp * mag(p2) + 16384) >>> 15;
      pcx = sat_s16(longint'($signed(f.nx)) + div_half_away(t * dx, q));
      pcy = sat_s16(longint'($signed(f.ny)) + div_half_away(t * dy, q));
    end
    pub_count = pub_count + 32'd1;
    b.cx = pcx[15:0]; b.cy = pcy[15:0];
    b.w = wp[14:0]; b.d = dp[14:0]; b.h = hp[14:0];
    b.gen = pub_count;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegThr:    thr_r = val[14:0];
      RegSigma:  sigma_r = val[11:0];
      RegMargin: margin_r = val[11:0];
      RegSensX:  sens_x_r = longint'($signed(val[15:0]));
      RegSensY:  sens_y_r = longint'($signed(val[15:0]));
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (fit_pending.size() != 0 || in_valid_i || box_expected.size() != 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic fit_t rand_fit(bit wild);
    fit_t f;
    f.cx = 16'($urandom); f.cy = 16'($urandom);
    f.w = 15'($urandom); f.d = 15'($urandom); f.h = 15'($urandom);
    f.yaw = 16'($signed($urandom_range(51472)) - 25736);
    f.wv = 20'($urandom); f.dv = 20'($urandom);
    f.belief = 1'($urandom); f.nx = 16'($urandom); f.ny = 16'($urandom);
    f.near_ok = $urandom_range(3) != 0;
    if (!wild) begin
      // small, mostly realistic boxes near the sensor
      f.cx = 16'($signed($urandom_range(8000)) - 4000);
      f.cy = 16'($signed($urandom_range(8000)) - 4000);
      f.w = 15'($urandom_range(4000)); f.d = 15'($urandom_range(4000));
      f.h = 15'($urandom_range(3000));
      f.wv = 20'($urandom_range(1 << ($urandom_range(20))));
      f.dv = 20'($urandom_range(1 << ($urandom_range(20))));
      f.nx = f.cx + 16'($signed($urandom_range(600)) - 300);
      f.ny = f.cy + 16'($signed($urandom_range(600)) - 300);
    end
    return f;
  endfunction

  // a jitter of the last fit, mostly below threshold
  function automatic fit_t jitter_fit(fit_t f);
    f.cx = f.cx + 16'($signed($urandom_range(80)) - 40);
    f.w = f.w + 15'($urandom_range(40));
    f.yaw = f.yaw + 16'($signed($urandom_range(900)) - 450);
    return f;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        box_t b;
        if (publish_footprint(fit_q, b)) box_expected.insert(box_expected.size(), b);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (hold_off && box_expected.size() != 0) begin
          in_valid_i <= 1'b0;
        end else if (fit_pending.size() != 0) begin
          if (drive_idle_ok && $urandom_range(5) == 0) begin
            gap_left <= $urandom_range(3);
            in_valid_i <= 1'b0;
          end else begin
            fit_q <= fit_pending.pop_front();
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (box_expected.size() == 0) begin
          report_mismatch("unexpected box, generation", box_o.gen, 0);
        end else begin
          box_t e;
          e = box_expected.pop_front();
          if (box_o.cx !== e.cx)
            report_mismatch("pub_center_x", $signed(box_o.cx), $signed(e.cx));
          if (box_o.cy !== e.cy)
            report_mismatch("pub_center_y", $signed(box_o.cy), $signed(e.cy));
          if (box_o.w !== e.w) report_mismatch("pub_width", box_o.w, e.w);
          if (box_o.d !== e.d) report_mismatch("pub_depth", box_o.d, e.d);
          if (box_o.h !== e.h) report_mismatch("pub_height", box_o.h, e.h);
          if (box_o.gen !== e.gen) report_mismatch("generation", box_o.gen, e.gen);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (drive_idle_ok && $urandom_range(4) == 0) begin
        stall_left <= $urandom_range(3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else if (!stim_done)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("tb_conservative_box_footprint_publisher_top: FAIL");
      $finish;
    end
  end

  initial begin
    fit_t f;
    thr_r = 51; sigma_r = 256; margin_r = 102; sens_x_r = 0; sens_y_r = 0;
    last_cx = 0; last_cy = 0; last_w = 0; last_d = 0; last_yaw = 0;
    pub_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special cases under reset settings
    f = '0; add_fit(f);
    f.w = 15'd52; add_fit(f);
    f = '0; f.yaw = 16'sd411; add_fit(f);
    f.yaw = 16'sd1; add_fit(f);
    f = '1; f.yaw = 16'sd25736; add_fit(f);
    f = '1; f.cx = 16'h8000; f.cy = 16'h7FFF; f.yaw = -16'sd25736;
    add_fit(f);
    f = '0; f.cx = 16'd1; f.w = 15'd200; f.near_ok = 1'b1; f.nx = 16'h7FFF;
    add_fit(f);
    f = '0; f.cx = 16'h7FFF; f.cy = 16'h7FFF; f.near_ok = 1'b1; f.belief = 1'b1;
    f.wv = 20'hFFFFF; f.dv = 20'hFFFFF; f.nx = 16'h7FFF; f.ny = 16'h7FFF;
    f.yaw = 16'sd12868; add_fit(f);
    f.cx = 16'h8000; f.cy = 16'h8000; f.nx = 16'h8000; f.ny = 16'h8000;
    f.yaw = -16'sd12868; add_fit(f);
    f.yaw = 16'h8000; add_fit(f);
    f.yaw = 16'h7FFF; add_fit(f);
    f.near_ok = 1'b0; f.cx = 16'd3000; add_fit(f);
    f.belief = 1'b0; f.cx = 16'd100; add_fit(f);
    wait_drained();

    // extreme settings, sensor at a box centre
    write_reg(RegThr, 32'h7FFF);
    write_reg(RegSigma, 32'hFFF);
    write_reg(RegMargin, 32'hFFF);
    write_reg(RegSensX, 32'h0000_7FFF);
    write_reg(RegSensY, 32'h0000_8000);
    write_reg(RegUnused, 32'h1234);
    f = '0; f.cx = 16'h7FFF; f.cy = 16'h8000; f.yaw = 16'sd1000; f.near_ok = 1'b1;
    f.belief = 1'b1; f.wv = 20'd1; add_fit(f);
    f.cx = 16'h8000; f.cy = 16'h7FFF; add_fit(f);
    wait_drained();

    write_reg(RegThr, 32'd0);
    write_reg(RegSigma, 32'd0);
    write_reg(RegMargin, 32'd0);
    write_reg(RegSensX, 32'hFFFF_8000);
    write_reg(RegSensY, 32'd0);
    f = '0; f.cx = 16'h8001; f.near_ok = 1'b1; add_fit(f);
    f.cx = 16'h8000; f.w = 15'd1; add_fit(f);
    wait_drained();

    // random phases with varying settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegThr, $urandom_range(3) == 0 ? $urandom_range(32767) : $urandom_range(120));
      write_reg(RegSigma, $urandom_range(4095));
      write_reg(RegMargin, $urandom_range(ph == 5 ? 4095 : 300));
      write_reg(RegSensX, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000) - 1000);
      write_reg(RegSensY, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000) - 1000);
      if (ph == 5) drive_idle_ok = 1'b0;
      hold_off = (ph == 2);
      for (int k = 0; k < 220; k++) begin
        if ($urandom_range(3) == 0 && k != 0) f = jitter_fit(f);
        else f = rand_fit($urandom_range(5) == 0);
        add_fit(f);
      end
      wait_drained();
    end

    stim_done = 1'b1;
    if (errors == 0) begin
      $display("tb_conservative_box_footprint_publisher_top: PASS");
    end else begin
      $display("tb_conservative_box_footprint_publisher_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
hdl/cbfp_pkg.sv
hdl/cbfp_ctrl.sv
hdl/cbfp_dp.sv
hdl/cbfp_regs.sv
hdl/conservative_box_footprint_publisher_top.sv
test/tb_conservative_box_footprint_publisher_top.sv
